// ===== sv/cmfs_pkg.sv =====
package cmfs_pkg;

    localparam int COMPONENT_BITS      = 16;
    localparam int UV_BITS             = 16;
    // One extra quotient bit covers a ratio of exactly +1, which saturates.
    localparam int QUOT_BITS           = UV_BITS + 1;
    localparam int REM_BITS            = COMPONENT_BITS + 1;
    localparam int DIV_STEPS_PER_STAGE = 2;

    localparam logic [2:0] FACE_POS_X = 3'd0;
    localparam logic [2:0] FACE_NEG_X = 3'd1;
    localparam logic [2:0] FACE_POS_Y = 3'd2;
    localparam logic [2:0] FACE_NEG_Y = 3'd3;
    localparam logic [2:0] FACE_POS_Z = 3'd4;
    localparam logic [2:0] FACE_NEG_Z = 3'd5;

    localparam logic [UV_BITS-1:0] UV_HALF = {1'b1, {(UV_BITS-1){1'b0}}};

    typedef struct packed {
        logic signed [COMPONENT_BITS-1:0] dir_x;
        logic signed [COMPONENT_BITS-1:0] dir_y;
        logic signed [COMPONENT_BITS-1:0] dir_z;
    } t_dir;

    typedef struct packed {
        logic [2:0]         face;
        logic [UV_BITS-1:0] tex_u;
        logic [UV_BITS-1:0] tex_v;
        logic               invalid;
    } t_coord;

    // First stage: the raw components, their magnitudes and the axis decision.
    typedef struct packed {
        logic signed [COMPONENT_BITS-1:0] x;
        logic signed [COMPONENT_BITS-1:0] y;
        logic signed [COMPONENT_BITS-1:0] z;
        logic [COMPONENT_BITS-1:0]        ax;
        logic [COMPONENT_BITS-1:0]        ay;
        logic [COMPONENT_BITS-1:0]        az;
        logic                             x_major;
        logic                             y_major;
        logic                             zero;
    } t_axis_stage;

    // Divider stages: twice the major magnitude is the divisor, and the
    // partial remainders and quotients of u and v travel together.
    typedef struct packed {
        logic [2:0]           face;
        logic                 invalid;
        logic [REM_BITS-1:0]  divisor;
        logic [REM_BITS-1:0]  rem_u;
        logic [REM_BITS-1:0]  rem_v;
        logic [QUOT_BITS-1:0] quot_u;
        logic [QUOT_BITS-1:0] quot_v;
    } t_div_stage;

    typedef struct packed {
        logic [REM_BITS-1:0] rem;
        logic                bit_q;
    } t_div_step;

    // One restoring division step. The first step compares the sum itself;
    // later steps shift the remainder left by one.
    function automatic t_div_step div_step(input logic [REM_BITS-1:0] rem,
                                           input logic [REM_BITS-1:0] divisor,
                                           input logic first);
        logic [REM_BITS:0] cand;
        t_div_step         res;
        cand = first ? {1'b0, rem} : {rem, 1'b0};
        if (cand >= {1'b0, divisor}) begin
            res.bit_q = 1'b1;
            res.rem   = REM_BITS'(cand - {1'b0, divisor});
        end else begin
            res.bit_q = 1'b0;
            res.rem   = cand[REM_BITS-1:0];
        end
        return res;
    endfunction

    function automatic logic [UV_BITS-1:0] sat_uv(input logic [QUOT_BITS-1:0] quot);
        return quot[QUOT_BITS-1] ? {UV_BITS{1'b1}} : quot[UV_BITS-1:0];
    endfunction

endpackage

// ===== sv/cube_map_face_select_top.sv =====
// Channel   Valid         Ready         Payload
// input     i_in_valid    o_in_ready    i_in_data  (t_dir: dir_x, dir_y, dir_z)
// output    o_out_valid   i_out_ready   o_out_data (t_coord: face, tex_u, tex_v, invalid)
//
// One transaction per cycle is accepted unless a stall at the output has filled the pipeline;
// each result passes the axis stage, the select stage and DIV_STAGES divider stages in order.
// The restoring divider yields one quotient bit per step, 17 bits deep.
// Reset is synchronous and active low; it clears only the stage valid bits.
// Each stage holds while the one after it is full and stalled, so empty stages
// keep filling while a finished result waits at the output.
module cube_map_face_select_top
    import cmfs_pkg::*;
#(
    parameter int STEPS_PER_STAGE = DIV_STEPS_PER_STAGE
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_in_valid,
    output logic   o_in_ready,
    input  t_dir   i_in_data,
    output logic   o_out_valid,
    input  logic   i_out_ready,
    output t_coord o_out_data
);

    localparam int DIV_STAGES = (QUOT_BITS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

    logic                    r_v_a;
    t_axis_stage             r_a;
    t_axis_stage             n_a;
    logic                    w_rdy_a;

    logic [DIV_STAGES:0]     r_v_d;
    t_div_stage              r_d [DIV_STAGES+1];
    t_div_stage              n_d [DIV_STAGES+1];
    logic [DIV_STAGES:0]     w_rdy_d;

    // Axis stage: magnitudes and the major-axis decision.
    always_comb begin
        n_a.x  = i_in_data.dir_x;
        n_a.y  = i_in_data.dir_y;
        n_a.z  = i_in_data.dir_z;
        n_a.ax = i_in_data.dir_x[COMPONENT_BITS-1] ?
                 (~$unsigned(i_in_data.dir_x) + COMPONENT_BITS'(1)) : $unsigned(i_in_data.dir_x);
        n_a.ay = i_in_data.dir_y[COMPONENT_BITS-1] ?
                 (~$unsigned(i_in_data.dir_y) + COMPONENT_BITS'(1)) : $unsigned(i_in_data.dir_y);
        n_a.az = i_in_data.dir_z[COMPONENT_BITS-1] ?
                 (~$unsigned(i_in_data.dir_z) + COMPONENT_BITS'(1)) : $unsigned(i_in_data.dir_z);
        n_a.x_major = (n_a.ax >= n_a.ay) && (n_a.ax >= n_a.az);
        n_a.y_major = (n_a.ay >= n_a.az);
        n_a.zero    = (n_a.ax == '0) && (n_a.ay == '0) && (n_a.az == '0);
    end

    // Select stage: face, signed numerators, and the dividend n + m.
    always_comb begin
        logic signed [COMPONENT_BITS:0]   wx;
        logic signed [COMPONENT_BITS:0]   wy;
        logic signed [COMPONENT_BITS:0]   wz;
        logic signed [COMPONENT_BITS:0]   nu;
        logic signed [COMPONENT_BITS:0]   nv;
        logic [COMPONENT_BITS-1:0]        m;
        logic signed [COMPONENT_BITS+1:0] su;
        logic signed [COMPONENT_BITS+1:0] sv;
        wx = {r_a.x[COMPONENT_BITS-1], r_a.x};
        wy = {r_a.y[COMPONENT_BITS-1], r_a.y};
        wz = {r_a.z[COMPONENT_BITS-1], r_a.z};
        n_d[0].face    = FACE_POS_X;
        n_d[0].invalid = r_a.zero;
        if (r_a.zero) begin
            // A zero vector divides 0 + 1 by 2, which gives exactly one half.
            nu = '0;
            nv = '0;
            m  = COMPONENT_BITS'(1);
        end else if (r_a.x_major) begin
            n_d[0].face = r_a.x[COMPONENT_BITS-1] ? FACE_NEG_X : FACE_POS_X;
            nu = r_a.x[COMPONENT_BITS-1] ? wz : -wz;
            nv = wy;
            m  = r_a.ax;
        end else if (r_a.y_major) begin
            n_d[0].face = r_a.y[COMPONENT_BITS-1] ? FACE_NEG_Y : FACE_POS_Y;
            nu = wx;
            nv = r_a.y[COMPONENT_BITS-1] ? wz : -wz;
            m  = r_a.ay;
        end else begin
            n_d[0].face = r_a.z[COMPONENT_BITS-1] ? FACE_NEG_Z : FACE_POS_Z;
            nu = r_a.z[COMPONENT_BITS-1] ? -wx : wx;
            nv = wy;
            m  = r_a.az;
        end
        su = {nu[COMPONENT_BITS], nu} + $signed({2'b00, m});
        sv = {nv[COMPONENT_BITS], nv} + $signed({2'b00, m});
        n_d[0].divisor = {m, 1'b0};
        n_d[0].rem_u   = su[REM_BITS-1:0];
        n_d[0].rem_v   = sv[REM_BITS-1:0];
        n_d[0].quot_u  = '0;
        n_d[0].quot_v  = '0;
    end

    assign w_rdy_a    = !r_v_a || w_rdy_d[0];
    assign o_in_ready = w_rdy_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_a    <= 1'b0;
            r_v_d[0] <= 1'b0;
        end else begin
            if (w_rdy_a) begin
                r_v_a <= i_in_valid;
            end
            if (w_rdy_d[0]) begin
                r_v_d[0] <= r_v_a;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_a && i_in_valid) begin
            r_a <= n_a;
        end
        if (w_rdy_d[0] && r_v_a) begin
            r_d[0] <= n_d[0];
        end
    end

    genvar k;
    generate
        for (k = 0; k < DIV_STAGES; k++) begin : g_div
            always_comb begin
                int        j;
                t_div_step su;
                t_div_step sv;
                j  = 0;
                su = '0;
                sv = '0;
                n_d[k+1] = r_d[k];
                for (int i = 0; i < STEPS_PER_STAGE; i++) begin
                    j = k * STEPS_PER_STAGE + i;
                    if (j < QUOT_BITS) begin
                        su = div_step(n_d[k+1].rem_u, r_d[k].divisor, j == 0);
                        sv = div_step(n_d[k+1].rem_v, r_d[k].divisor, j == 0);
                        n_d[k+1].rem_u = su.rem;
                        n_d[k+1].rem_v = sv.rem;
                        n_d[k+1].quot_u[QUOT_BITS-1-j] = su.bit_q;
                        n_d[k+1].quot_v[QUOT_BITS-1-j] = sv.bit_q;
                    end
                end
            end

            assign w_rdy_d[k] = !r_v_d[k] || w_rdy_d[k+1];

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v_d[k+1] <= 1'b0;
                end else if (w_rdy_d[k+1]) begin
                    r_v_d[k+1] <= r_v_d[k];
                end
            end

            always_ff @(posedge i_clk) begin
                if (w_rdy_d[k+1] && r_v_d[k]) begin
                    r_d[k+1] <= n_d[k+1];
                end
            end
        end
    endgenerate

    assign w_rdy_d[DIV_STAGES] = !r_v_d[DIV_STAGES] || i_out_ready;

    assign o_out_valid        = r_v_d[DIV_STAGES];
    assign o_out_data.face    = r_d[DIV_STAGES].face;
    assign o_out_data.tex_u   = sat_uv(r_d[DIV_STAGES].quot_u);
    assign o_out_data.tex_v   = sat_uv(r_d[DIV_STAGES].quot_v);
    assign o_out_data.invalid = r_d[DIV_STAGES].invalid;

`ifndef NO_ASSERTIONS
    // The minor numerators never exceed the major magnitude, so each dividend
    // lies in [0, divisor] and the divisor is never zero.
    a_dividend_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v_d[0] |-> (r_d[0].divisor != '0) && (r_d[0].rem_u <= r_d[0].divisor) &&
                     (r_d[0].rem_v <= r_d[0].divisor))
        else $error("dividend out of range at divider entry");

    a_final_remainder: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v_d[DIV_STAGES] |-> (r_d[DIV_STAGES].rem_u < r_d[DIV_STAGES].divisor) &&
                              (r_d[DIV_STAGES].rem_v < r_d[DIV_STAGES].divisor))
        else $error("division did not converge");

    // A quotient of exactly one leaves all lower quotient bits clear.
    a_sat_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v_d[DIV_STAGES] && r_d[DIV_STAGES].quot_u[QUOT_BITS-1]) |->
            (r_d[DIV_STAGES].quot_u[UV_BITS-1:0] == '0))
        else $error("quotient above one");

    a_zero_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.invalid) |->
            (o_out_data.face == FACE_POS_X) && (o_out_data.tex_u == UV_HALF) &&
            (o_out_data.tex_v == UV_HALF))
        else $error("zero vector result malformed");
`endif

endmodule

// ===== dv/cmfs_coord_checker.sv =====
`timescale 1ns / 100ps

module cmfs_coord_checker
    import cmfs_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_in_valid,
    input  logic   i_in_ready,
    input  t_dir   i_in_data,
    input  logic   i_out_valid,
    input  logic   i_out_ready,
    input  t_coord i_out_data,
    output int     o_mismatches,
    output int     o_pending
);

    localparam longint UV_TOP = (longint'(1) << UV_BITS) - 1;

    t_coord coords_due[$];
    t_coord oldest;
    int     mismatch_total = 0;
    int     due_total      = 0;

    assign o_mismatches = mismatch_total;
    assign o_pending    = due_total;

    // Maps num/den, with |num| <= den and den > 0, onto [0, 1] as a
    // truncated and saturated unsigned fraction.
    function automatic logic [UV_BITS-1:0] ratio_to_uv(input longint num, input longint den);
        longint shifted;
        longint quot;
        shifted = num + den;
        if (shifted <= 0) begin
            return '0;
        end
        quot = (shifted << (UV_BITS - 1)) / den;
        if (quot > UV_TOP) begin
            return '1;
        end
        return quot[UV_BITS-1:0];
    endfunction

    function automatic t_coord predict_coord(input t_dir dir);
        longint x;
        longint y;
        longint z;
        longint ax;
        longint ay;
        longint az;
        t_coord c;
        x  = longint'($signed(dir.dir_x));
        y  = longint'($signed(dir.dir_y));
        z  = longint'($signed(dir.dir_z));
        ax = (x < 0) ? -x : x;
        ay = (y < 0) ? -y : y;
        az = (z < 0) ? -z : z;
        c.invalid = 1'b0;
        if (ax == 0 && ay == 0 && az == 0) begin
            // The direction is undefined, so the face center stands in for it.
            c.face    = FACE_POS_X;
            c.tex_u   = UV_HALF;
            c.tex_v   = UV_HALF;
            c.invalid = 1'b1;
        end else if (ax >= ay && ax >= az) begin
            c.face  = (x >= 0) ? FACE_POS_X : FACE_NEG_X;
            c.tex_u = ratio_to_uv((x >= 0) ? -z : z, ax);
            c.tex_v = ratio_to_uv(y, ax);
        end else if (ay >= az) begin
            c.face  = (y >= 0) ? FACE_POS_Y : FACE_NEG_Y;
            c.tex_u = ratio_to_uv(x, ay);
            c.tex_v = ratio_to_uv((y >= 0) ? -z : z, ay);
        end else begin
            c.face  = (z >= 0) ? FACE_POS_Z : FACE_NEG_Z;
            c.tex_u = ratio_to_uv((z >= 0) ? x : -x, az);
            c.tex_v = ratio_to_uv(y, az);
        end
        return c;
    endfunction

    task automatic report_field(input string field, input logic [UV_BITS-1:0] wanted,
                                input logic [UV_BITS-1:0] seen);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, wanted, seen);
        mismatch_total++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && i_in_ready) begin
                coords_due.push_back(predict_coord(i_in_data));
            end
            if (i_out_valid && i_out_ready) begin
                if (coords_due.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %p",
                             $time, i_out_data);
                    mismatch_total++;
                end else begin
                    oldest = coords_due.pop_front();
                    if (i_out_data.face !== oldest.face) begin
                        report_field("face", UV_BITS'(oldest.face), UV_BITS'(i_out_data.face));
                    end
                    if (i_out_data.tex_u !== oldest.tex_u) begin
                        report_field("tex_u", oldest.tex_u, i_out_data.tex_u);
                    end
                    if (i_out_data.tex_v !== oldest.tex_v) begin
                        report_field("tex_v", oldest.tex_v, i_out_data.tex_v);
                    end
                    if (i_out_data.invalid !== oldest.invalid) begin
                        report_field("invalid", UV_BITS'(oldest.invalid),
                                     UV_BITS'(i_out_data.invalid));
                    end
                end
            end
            due_total = coords_due.size();
        end
    end

endmodule

// ===== dv/cube_map_face_select_top_test.sv =====
`timescale 1ns / 100ps

module cube_map_face_select_top_test;
    import cmfs_pkg::*;

    localparam int RANDOM_DIRS = 1800;

    logic   clk;
    logic   rst_n;
    logic   in_valid;
    logic   in_ready;
    t_dir   in_data;
    logic   out_valid;
    logic   out_ready;
    t_coord out_data;
    int     mismatches;
    int     pending;

    bit sender_calm = 1'b0;
    bit sink_calm   = 1'b0;
    int dirs_sent   = 0;

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    cube_map_face_select_top u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    cmfs_coord_checker u_coord_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    function automatic logic [COMPONENT_BITS-1:0] extreme_component();
        case ($urandom_range(0, 6))
            0: return 16'sh8000;
            1: return 16'sh8001;
            2: return 16'shffff;
            3: return 16'sh0000;
            4: return 16'sh0001;
            5: return 16'sh7fff;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_dir random_dir();
        t_dir                      d;
        logic [COMPONENT_BITS-1:0] mag;
        d.dir_x = 16'($urandom);
        d.dir_y = 16'($urandom);
        d.dir_z = 16'($urandom);
        case ($urandom_range(0, 9))
            4: begin
                // Tiny components reach the zero vector and exact ties often.
                d.dir_x = 16'($urandom_range(0, 6)) - 16'd3;
                d.dir_y = 16'($urandom_range(0, 6)) - 16'd3;
                d.dir_z = 16'($urandom_range(0, 6)) - 16'd3;
            end
            5: begin
                // Equal magnitudes exercise the tie order and ratios of +1 and -1.
                mag = 16'($urandom);
                d.dir_x = $urandom_range(0, 1) ? mag : -mag;
                d.dir_y = $urandom_range(0, 1) ? mag : -mag;
                if ($urandom_range(0, 1)) begin
                    d.dir_z = $urandom_range(0, 1) ? mag : -mag;
                end
                if ($urandom_range(0, 2) == 0) begin
                    {d.dir_x, d.dir_z} = {d.dir_z, d.dir_x};
                end
            end
            6: begin
                d.dir_x = extreme_component();
                d.dir_y = extreme_component();
                d.dir_z = extreme_component();
            end
            7: begin
                case ($urandom_range(0, 2))
                    0: d.dir_x = extreme_component();
                    1: d.dir_y = extreme_component();
                    default: d.dir_z = extreme_component();
                endcase
            end
            default: ;
        endcase
        return d;
    endfunction

    // Entered at a rising edge; returns at the edge where the transaction is taken.
    task automatic send_dir(input t_dir dir);
        int gap;
        bit ready_seen;
        gap = sender_calm ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= dir;
        do begin
            @(negedge clk);
            ready_seen = in_ready;
            @(posedge clk);
        end while (!ready_seen);
        dirs_sent++;
        if (dirs_sent % 100 == 0) begin
            sender_calm = ($urandom_range(0, 3) == 0);
        end
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        do begin
            @(negedge clk);
        end while (pending != 0);
        @(posedge clk);
    endtask

    initial begin
        int  stall;
        int  taken;
        bit  valid_seen;
        taken = 0;
        out_ready <= 1'b0;
        @(posedge clk);
        forever begin
            stall = sink_calm ? 0 : $urandom_range(0, 12);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do begin
                @(negedge clk);
                valid_seen = out_valid;
                @(posedge clk);
            end while (!valid_seen);
            taken++;
            if (taken % 100 == 0) begin
                sink_calm = ($urandom_range(0, 3) == 0);
            end
        end
    end

    initial begin
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_data  <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        send_dir('{16'sd0, 16'sd0, 16'sd0});
        send_dir('{16'sh7fff, 16'sd0, 16'sd0});
        send_dir('{16'sh8000, 16'sd0, 16'sd0});
        send_dir('{16'sd0, 16'sh7fff, 16'sd0});
        send_dir('{16'sd0, 16'sh8000, 16'sd0});
        send_dir('{16'sd0, 16'sd0, 16'sh7fff});
        send_dir('{16'sd0, 16'sd0, 16'sh8000});
        send_dir('{16'sh8000, 16'sh8000, 16'sh8000});
        send_dir('{16'sh7fff, 16'sh7fff, 16'sh7fff});
        send_dir('{16'sh8000, 16'sh7fff, 16'sh8001});
        send_dir('{16'sd500, -16'sd500, 16'sd200});
        send_dir('{16'sd10, -16'sd300, 16'sd300});
        send_dir('{16'sd1, 16'sd0, 16'sd0});
        send_dir('{16'sd0, -16'sd1, 16'sd0});
        send_dir('{16'sd0, 16'sd0, 16'sd1});
        send_dir('{-16'sd1, -16'sd1, 16'sd1});
        send_dir('{16'sd1000, -16'sd1000, -16'sd1000});
        send_dir('{16'sd300, 16'sd100, -16'sd400});
        send_dir('{-16'sd7, 16'sd3, -16'sd2});
        send_dir('{16'sd12345, -16'sd23456, 16'sd30000});
        send_dir('{-16'sd20000, 16'sd20000, -16'sd19999});
        send_dir('{16'sd0, 16'sh7fff, 16'sh8000});
        send_dir('{16'sh8000, 16'sd0, 16'sh7fff});

        for (int i = 0; i < RANDOM_DIRS; i++) begin
            // Let the pipeline empty completely once, then refill it from cold.
            if (i == RANDOM_DIRS / 2) begin
                wait_for_results();
            end
            send_dir(random_dir());
        end

        wait_for_results();
        repeat (20) @(posedge clk);
        @(negedge clk);
        if (mismatches == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
